@@ rtl/deq_pkg.sv @@
// ---------------------------------------------------------------------------
// deq_pkg: shared types and constants for the double-ended queue
// Request and status codes, payload widths and the default ring depth.
// ---------------------------------------------------------------------------
package deq_pkg;

	localparam int DEF_CAPACITY = 1024;
	localparam int DATA_W       = 32;
	localparam int IDX_W        = 10;
	localparam int COUNT_W      = 11;
	localparam int REQ_W        = 3;
	localparam int STATUS_W     = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_BACK  = 3'd0,
		REQ_PUSH_FRONT = 3'd1,
		REQ_POP_BACK   = 3'd2,
		REQ_POP_FRONT  = 3'd3,
		REQ_READ       = 3'd4,
		REQ_WRITE      = 3'd5,
		REQ_CLEAR      = 3'd6
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

endpackage

@@ rtl/deq_ram.sv @@
// ---------------------------------------------------------------------------
// deq_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module deq_ram #(
	parameter int WIDTH = deq_pkg::DATA_W,
	parameter int DEPTH = deq_pkg::DEF_CAPACITY
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/double_ended_queue.sv @@
// ---------------------------------------------------------------------------
// double_ended_queue: deque of signed 32-bit words in a ring buffer
// Push/pop at either end, indexed read/write from the front, and clear.
// ---------------------------------------------------------------------------
// Usage:
//   Drive req_type, value and index with start high. A request is taken at
//   a rising edge where start is high and busy is low; busy stays low, so a
//   request can be issued every cycle.
//   Exactly one result beat follows each request, in the cycle after it was
//   taken: valid is high for that single cycle with read_data, count and
//   status. Throughput is one request per cycle; read_data comes from the
//   registered read port of the ring RAM.
//   The receiver cannot stall; results must be taken as they appear.
//   Full pushes and empty pops change nothing and are flagged; an index at
//   or beyond count is flagged and never touches the RAM.
//   Reset clears the front pointer and element count (an empty deque); the
//   RAM itself is not cleared since no slot is read before it is written.
//   CAPACITY sets the ring depth; positions are reached through index.
// ---------------------------------------------------------------------------
module double_ended_queue #(
	parameter int CAPACITY = deq_pkg::DEF_CAPACITY
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [deq_pkg::REQ_W-1:0]            req_type,
	input  logic signed [deq_pkg::DATA_W-1:0]    value,
	input  logic [deq_pkg::IDX_W-1:0]            index,
	output logic                                 valid,
	output logic signed [deq_pkg::DATA_W-1:0]    read_data,
	output logic [deq_pkg::COUNT_W-1:0]          count,
	output logic [deq_pkg::STATUS_W-1:0]         status
);

	localparam int PW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = ((CW > deq_pkg::IDX_W) ? CW : deq_pkg::IDX_W) + 1;

	logic [PW-1:0] front_q;
	logic [CW-1:0] cnt_q;

	logic                     accept;
	logic [AW-1:0]            cap_ext, cnt_ext, idx_ext, front_ext;
	logic [AW-1:0]            back_sum, idx_sum;
	logic [PW-1:0]            back_slot, idx_slot, front_dec, front_inc;
	logic                     full, empty, in_range;
	logic [PW-1:0]            front_nxt;
	logic [CW-1:0]            cnt_nxt;
	deq_pkg::status_t         st_nxt;
	logic                     we, rd_ok;
	logic [PW-1:0]            waddr;
	logic [deq_pkg::DATA_W-1:0] ram_rdata;

	logic                     valid_s1;
	logic                     rd_ok_s1;
	logic [CW-1:0]            count_s1;
	deq_pkg::status_t         status_s1;
	logic [AW-1:0]            count_ext;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_comb begin
		cap_ext   = AW'(CAPACITY);
		cnt_ext   = AW'(cnt_q);
		idx_ext   = AW'(index);
		front_ext = AW'(front_q);
		full      = (cnt_q == CW'(CAPACITY));
		empty     = (cnt_q == '0);
		in_range  = (idx_ext < cnt_ext);

		// both sums stay below twice the depth (index in range): one subtract wraps
		back_sum  = front_ext + cnt_ext;
		back_slot = (back_sum >= cap_ext) ? PW'(back_sum - cap_ext) : PW'(back_sum);
		idx_sum   = front_ext + idx_ext;
		idx_slot  = (idx_sum >= cap_ext) ? PW'(idx_sum - cap_ext) : PW'(idx_sum);

		front_dec = (front_q == '0) ? PW'(CAPACITY - 1) : front_q - PW'(1);
		front_inc = (front_q == PW'(CAPACITY - 1)) ? '0 : front_q + PW'(1);

		front_nxt = front_q;
		cnt_nxt   = cnt_q;
		st_nxt    = deq_pkg::ST_OK;
		we        = 1'b0;
		waddr     = idx_slot;
		rd_ok     = 1'b0;

		unique case (deq_pkg::req_t'(req_type))
			deq_pkg::REQ_PUSH_BACK: begin
				if (full) begin
					st_nxt = deq_pkg::ST_FULL;
				end else begin
					we      = 1'b1;
					waddr   = back_slot;
					cnt_nxt = cnt_q + CW'(1);
				end
			end
			deq_pkg::REQ_PUSH_FRONT: begin
				if (full) begin
					st_nxt = deq_pkg::ST_FULL;
				end else begin
					we        = 1'b1;
					waddr     = front_dec;
					front_nxt = front_dec;
					cnt_nxt   = cnt_q + CW'(1);
				end
			end
			deq_pkg::REQ_POP_BACK: begin
				if (empty) begin
					st_nxt = deq_pkg::ST_EMPTY;
				end else begin
					cnt_nxt = cnt_q - CW'(1);
				end
			end
			deq_pkg::REQ_POP_FRONT: begin
				if (empty) begin
					st_nxt = deq_pkg::ST_EMPTY;
				end else begin
					front_nxt = front_inc;
					cnt_nxt   = cnt_q - CW'(1);
				end
			end
			deq_pkg::REQ_READ: begin
				if (in_range) begin
					rd_ok = 1'b1;
				end else begin
					st_nxt = deq_pkg::ST_RANGE;
				end
			end
			deq_pkg::REQ_WRITE: begin
				if (in_range) begin
					we = 1'b1;
				end else begin
					st_nxt = deq_pkg::ST_RANGE;
				end
			end
			deq_pkg::REQ_CLEAR: begin
				front_nxt = '0;
				cnt_nxt   = '0;
			end
			default: begin
				// unused code: leave state alone
			end
		endcase
	end

	deq_ram #(
		.WIDTH(deq_pkg::DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (accept && we),
		.waddr (waddr),
		.wdata (value),
		.re    (accept && rd_ok),
		.raddr (idx_slot),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				front_q <= front_nxt;
				cnt_q   <= cnt_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_ok_s1  <= rd_ok;
			count_s1  <= cnt_nxt;
			status_s1 <= st_nxt;
		end
	end

	assign count_ext = AW'(count_s1);
	assign valid     = valid_s1;
	assign read_data = rd_ok_s1 ? signed'(ram_rdata) : '0;
	assign count     = count_ext[deq_pkg::COUNT_W-1:0];
	assign status    = status_s1;

`ifndef SYNTHESIS
	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		valid == $past(accept))
		else $error("result beat does not follow its request");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("element count beyond capacity");

	a_front_bound: assert property (@(posedge clk) disable iff (!arst_n)
		front_q <= PW'(CAPACITY - 1))
		else $error("front pointer outside the ring");

	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && status_s1 == deq_pkg::ST_FULL) |-> count_s1 == CW'(CAPACITY))
		else $error("full flagged while not full");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !rd_ok_s1) |-> read_data == '0)
		else $error("read data on a non-read result");
`endif

endmodule

@@ tb/tb_double_ended_queue.sv @@
// ---------------------------------------------------------------------------
// tb_double_ended_queue: self-checking bench for the ring-buffer deque
// Walks a short script of edge cases (empty pops, range errors, extreme
// words, pointer wrap), then random traffic that fills the ring to full,
// drains it and mixes all requests. Every result beat is checked against
// a typed-in script expectation or a behavioral deque kept in the bench.
// ---------------------------------------------------------------------------
module tb_double_ended_queue;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = deq_pkg::DEF_CAPACITY;
	localparam logic [deq_pkg::REQ_W-1:0] REQ_UNUSED = 3'd7;
	localparam int SCRIPT_LEN = 24;

	typedef struct packed {
		logic signed [deq_pkg::DATA_W-1:0] data;
		logic [deq_pkg::COUNT_W-1:0]       cnt;
		logic [deq_pkg::STATUS_W-1:0]      st;
	} deq_result_t;

	typedef struct packed {
		logic [deq_pkg::REQ_W-1:0]         req;
		logic signed [deq_pkg::DATA_W-1:0] val;
		logic [deq_pkg::IDX_W-1:0]         idx;
		bit                                typed;
		deq_result_t                       want;
	} script_row_t;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 start;
	logic                                 busy;
	logic [deq_pkg::REQ_W-1:0]            req_type;
	logic signed [deq_pkg::DATA_W-1:0]    value;
	logic [deq_pkg::IDX_W-1:0]            index;
	logic                                 valid;
	logic signed [deq_pkg::DATA_W-1:0]    read_data;
	logic [deq_pkg::COUNT_W-1:0]          count;
	logic [deq_pkg::STATUS_W-1:0]         status;

	// typed-in expectation travels with the beat it belongs to
	bit                                   typed_row;
	deq_result_t                          typed_result;

	// behavioral deque
	logic signed [deq_pkg::DATA_W-1:0]    ring_words [CAP];
	int                                   ring_head;
	int                                   ring_depth;

	deq_result_t                          pending_results [$];
	int                                   fail_count;
	int                                   idle_pct;
	int                                   n_accepted;
	int                                   n_full;
	int                                   n_empty;
	int                                   n_range;
	int                                   peak_depth;

	script_row_t script_rows [SCRIPT_LEN] = '{
		'{deq_pkg::REQ_POP_BACK,   32'sd0,       10'd0,    1'b1,
			'{32'sd0,       11'd0, deq_pkg::ST_EMPTY}},
		'{deq_pkg::REQ_POP_FRONT,  32'sd0,       10'd0,    1'b1,
			'{32'sd0,       11'd0, deq_pkg::ST_EMPTY}},
		'{deq_pkg::REQ_READ,       32'sd0,       10'd0,    1'b1,
			'{32'sd0,       11'd0, deq_pkg::ST_RANGE}},
		'{deq_pkg::REQ_WRITE,      32'sd5,       10'd0,    1'b1,
			'{32'sd0,       11'd0, deq_pkg::ST_RANGE}},
		'{deq_pkg::REQ_PUSH_BACK,  32'h7FFFFFFF, 10'd0,    1'b1,
			'{32'sd0,       11'd1, deq_pkg::ST_OK}},
		'{deq_pkg::REQ_PUSH_FRONT, 32'h80000000, 10'd1023, 1'b1,
			'{32'sd0,       11'd2, deq_pkg::ST_OK}},
		'{deq_pkg::REQ_READ,       32'sd0,       10'd0,    1'b1,
			'{32'h80000000, 11'd2, deq_pkg::ST_OK}},
		'{deq_pkg::REQ_READ,       32'sd0,       10'd1,    1'b1,
			'{32'h7FFFFFFF, 11'd2, deq_pkg::ST_OK}},
		'{deq_pkg::REQ_READ,       32'sd0,       10'd2,    1'b1,
			'{32'sd0,       11'd2, deq_pkg::ST_RANGE}},
		'{deq_pkg::REQ_READ,       32'sd0,       10'd1023, 1'b1,
			'{32'sd0,       11'd2, deq_pkg::ST_RANGE}},
		'{deq_pkg::REQ_WRITE,      -32'sd1,      10'd1,    1'b1,
			'{32'sd0,       11'd2, deq_pkg::ST_OK}},
		'{deq_pkg::REQ_READ,       32'sd0,       10'd1,    1'b1,
			'{-32'sd1,      11'd2, deq_pkg::ST_OK}},
		'{deq_pkg::REQ_PUSH_FRONT, 32'sd0,       10'd0,    1'b0,
			'{32'sd0,       11'd0, deq_pkg::ST_OK}},
		'{deq_pkg::REQ_PUSH_BACK,  32'sd1,       10'd0,    1'b0,
			'{32'sd0,       11'd0, deq_pkg::ST_OK}},
		'{deq_pkg::REQ_POP_BACK,   32'sd0,       10'd0,    1'b0,
			'{32'sd0,       11'd0, deq_pkg::ST_OK}},
		'{deq_pkg::REQ_POP_FRONT,  32'sd0,       10'd0,    1'b0,
			'{32'sd0,       11'd0, deq_pkg::ST_OK}},
		'{REQ_UNUSED,              -32'sd1,      10'd1023, 1'b1,
			'{32'sd0,       11'd2, deq_pkg::ST_OK}},
		'{deq_pkg::REQ_CLEAR,      32'sd0,       10'd0,    1'b1,
			'{32'sd0,       11'd0, deq_pkg::ST_OK}},
		'{deq_pkg::REQ_POP_FRONT,  32'sd0,       10'd0,    1'b1,
			'{32'sd0,       11'd0, deq_pkg::ST_EMPTY}},
		'{deq_pkg::REQ_PUSH_FRONT, 32'hAAAAAAAA, 10'd0,    1'b1,
			'{32'sd0,       11'd1, deq_pkg::ST_OK}},
		'{deq_pkg::REQ_WRITE,      32'h55555555, 10'd0,    1'b0,
			'{32'sd0,       11'd0, deq_pkg::ST_OK}},
		'{deq_pkg::REQ_READ,       32'sd0,       10'd0,    1'b0,
			'{32'sd0,       11'd0, deq_pkg::ST_OK}},
		'{deq_pkg::REQ_POP_FRONT,  32'sd0,       10'd0,    1'b0,
			'{32'sd0,       11'd0, deq_pkg::ST_OK}},
		'{deq_pkg::REQ_READ,       32'sd0,       10'd0,    1'b1,
			'{32'sd0,       11'd0, deq_pkg::ST_RANGE}}
	};

	double_ended_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req_type  (req_type),
		.value     (value),
		.index     (index),
		.valid     (valid),
		.read_data (read_data),
		.count     (count),
		.status    (status)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Apply one request to the behavioral deque and return its result beat.
	function automatic deq_result_t apply_request(input logic [deq_pkg::REQ_W-1:0] rq,
			input logic signed [deq_pkg::DATA_W-1:0] val,
			input logic [deq_pkg::IDX_W-1:0] idx);
		deq_result_t r;
		r = '0;
		r.st = deq_pkg::ST_OK;
		case (rq) inside
			deq_pkg::REQ_PUSH_BACK, deq_pkg::REQ_PUSH_FRONT: begin
				if (ring_depth >= CAP) begin
					r.st = deq_pkg::ST_FULL;
				end else if (rq == deq_pkg::REQ_PUSH_BACK) begin
					ring_words[(ring_head + ring_depth) % CAP] = val;
					ring_depth++;
				end else begin
					ring_head = (ring_head + CAP - 1) % CAP;
					ring_words[ring_head] = val;
					ring_depth++;
				end
			end
			deq_pkg::REQ_POP_BACK, deq_pkg::REQ_POP_FRONT: begin
				if (ring_depth == 0) begin
					r.st = deq_pkg::ST_EMPTY;
				end else begin
					if (rq == deq_pkg::REQ_POP_FRONT)
						ring_head = (ring_head + 1) % CAP;
					ring_depth--;
				end
			end
			deq_pkg::REQ_READ: begin
				if (int'(idx) >= ring_depth)
					r.st = deq_pkg::ST_RANGE;
				else
					r.data = ring_words[(ring_head + int'(idx)) % CAP];
			end
			deq_pkg::REQ_WRITE: begin
				if (int'(idx) >= ring_depth)
					r.st = deq_pkg::ST_RANGE;
				else
					ring_words[(ring_head + int'(idx)) % CAP] = val;
			end
			deq_pkg::REQ_CLEAR: begin
				ring_head = 0;
				ring_depth = 0;
			end
			default: ;
		endcase
		r.cnt = ring_depth[deq_pkg::COUNT_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what,
			input logic [deq_pkg::DATA_W-1:0] got,
			input logic [deq_pkg::DATA_W-1:0] want);
		$display("MISMATCH at %0t ns: %s got %h want %h", $time, what, got, want);
		fail_count++;
	endtask

	// accept side: predict; result side: compare against the oldest expectation
	always @(posedge clk) begin : beat_monitor
		deq_result_t model_res;
		deq_result_t want;
		if (arst_n && start && !busy) begin
			model_res = apply_request(req_type, value, index);
			n_accepted++;
			if (model_res.st == deq_pkg::ST_FULL) n_full++;
			if (model_res.st == deq_pkg::ST_EMPTY) n_empty++;
			if (model_res.st == deq_pkg::ST_RANGE) n_range++;
			if (ring_depth > peak_depth) peak_depth = ring_depth;
			pending_results.push_back(typed_row ? typed_result : model_res);
		end
		if (arst_n && valid) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with nothing pending", read_data, '0);
			end else begin
				want = pending_results.pop_front();
				if (read_data !== want.data)
					report_mismatch("read_data", read_data, want.data);
				if (count !== want.cnt)
					report_mismatch("count", {21'd0, count}, {21'd0, want.cnt});
				if (status !== want.st)
					report_mismatch("status", {30'd0, status}, {30'd0, want.st});
			end
		end
	end

	task automatic issue(input logic [deq_pkg::REQ_W-1:0] rq,
			input logic signed [deq_pkg::DATA_W-1:0] val,
			input logic [deq_pkg::IDX_W-1:0] idx, input bit typed, input deq_result_t tres);
		int gap;
		gap = 0;
		start <= 1'b1;
		req_type <= rq;
		value <= val;
		index <= idx;
		typed_row <= typed;
		typed_result <= tres;
		@(posedge clk);
		while (busy) @(posedge clk);
		while (gap < 40 && $urandom_range(99, 0) < idle_pct) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic signed [deq_pkg::DATA_W-1:0] pick_word();
		case ($urandom_range(15, 0))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return -32'sd1;
			3: return 32'sd0;
			default: return $urandom;
		endcase
	endfunction

	// mostly in-range positions; the rest land exactly on the count or anywhere
	function automatic logic [deq_pkg::IDX_W-1:0] pick_index();
		if (ring_depth > 0 && $urandom_range(99, 0) < 80)
			return deq_pkg::IDX_W'($urandom_range(ring_depth - 1, 0));
		if (ring_depth < CAP && $urandom_range(1, 0) == 1)
			return ring_depth[deq_pkg::IDX_W-1:0];
		return deq_pkg::IDX_W'($urandom_range(CAP - 1, 0));
	endfunction

	// phase 0 fills toward full, phase 1 drains, phase 2 mixes everything
	task automatic random_request(input int phase);
		int roll;
		logic [deq_pkg::REQ_W-1:0] rq;
		roll = $urandom_range(99, 0);
		case (phase)
			0: rq = roll < 46 ? deq_pkg::REQ_PUSH_BACK : roll < 92 ? deq_pkg::REQ_PUSH_FRONT :
				roll < 93 ? deq_pkg::REQ_POP_BACK : roll < 94 ? deq_pkg::REQ_POP_FRONT :
				roll < 97 ? deq_pkg::REQ_READ : roll < 99 ? deq_pkg::REQ_WRITE : REQ_UNUSED;
			1: rq = roll < 8 ? deq_pkg::REQ_PUSH_BACK : roll < 16 ? deq_pkg::REQ_PUSH_FRONT :
				roll < 50 ? deq_pkg::REQ_POP_BACK : roll < 84 ? deq_pkg::REQ_POP_FRONT :
				roll < 92 ? deq_pkg::REQ_READ : roll < 98 ? deq_pkg::REQ_WRITE :
				roll < 99 ? deq_pkg::REQ_CLEAR : REQ_UNUSED;
			default: rq = roll < 20 ? deq_pkg::REQ_PUSH_BACK :
				roll < 40 ? deq_pkg::REQ_PUSH_FRONT :
				roll < 55 ? deq_pkg::REQ_POP_BACK : roll < 70 ? deq_pkg::REQ_POP_FRONT :
				roll < 83 ? deq_pkg::REQ_READ : roll < 95 ? deq_pkg::REQ_WRITE :
				roll < 98 ? deq_pkg::REQ_CLEAR : REQ_UNUSED;
		endcase
		issue(rq, pick_word(), pick_index(), 1'b0, '0);
	endtask

	initial begin
		int phase_len [3];
		int phase_idle [3];
		int waited;
		phase_len = '{1200, 250, 300};
		phase_idle = '{31, 74, 0};
		fail_count = 0;
		n_accepted = 0;
		n_full = 0;
		n_empty = 0;
		n_range = 0;
		peak_depth = 0;
		ring_head = 0;
		ring_depth = 0;
		idle_pct = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		req_type <= '0;
		value <= '0;
		index <= '0;
		typed_row <= 1'b0;
		typed_result <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = phase_idle[0];
		foreach (script_rows[i])
			issue(script_rows[i].req, script_rows[i].val, script_rows[i].idx,
				script_rows[i].typed, script_rows[i].want);

		for (int p = 0; p < 3; p++) begin
			idle_pct = phase_idle[p];
			for (int n = 0; n < phase_len[p]; n++)
				random_request(p);
		end
		start <= 1'b0;

		// drain: wait until every pending result beat has come back
		waited = 0;
		while (pending_results.size() != 0 && waited < 100) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never returned", pending_results.size(), '0);

		$display("Ran %0d requests through fill, drain and mixed traffic, peak depth %0d",
			n_accepted, peak_depth);
		$display("Flags seen: %0d full pushes, %0d empty pops, %0d out-of-range accesses",
			n_full, n_empty, n_range);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
